@@ design/cfa_pkg.sv @@
// Shared types, field widths and codes for the contiguous fit allocator.
// Used by the fit unit, the top level and the testbench; depends on nothing else.
package cfa_pkg;

    localparam int MEM_CELLS_DEF = 4096;
    localparam int ID_BITS_DEF   = 16;

    localparam int MODE_W   = 2;
    localparam int SIZE_W   = 13;
    localparam int AID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int BASE_W   = 12;
    localparam int GID_W    = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int IN_PAD_W    = IN_TDATA_W - MODE_W - SIZE_W - AID_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - BASE_W - GID_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_BEST  = 2'd0,
        MODE_WORST = 2'd1,
        MODE_FIRST = 2'd2,
        MODE_FREE  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_ZERO    = 2'd2,
        ST_NOID    = 2'd3
    } status_t;

    typedef struct packed {
        logic clear;
        logic cell_vld;
        logic cell_free;
        logic flush;
    } fit_ctl_t;

endpackage

@@ design/cfa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the cell ownership map; depends on nothing else.
module cfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/cfa_fit_unit.sv @@
// Run tracker and fit comparator: measures free runs cell by cell and keeps the chosen one.
// Depends on cfa_pkg for the mode codes and the control struct.
module cfa_fit_unit #(
    parameter int MEM_CELLS = cfa_pkg::MEM_CELLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfa_pkg::fit_ctl_t            ctl,
    input  cfa_pkg::mode_t               mode,
    input  logic [cfa_pkg::SIZE_W-1:0]   need,
    input  logic [$clog2(MEM_CELLS)-1:0] cell_idx,
    output logic                         found,
    output logic [$clog2(MEM_CELLS)-1:0] best_start
);
    import cfa_pkg::*;

    localparam int AW = $clog2(MEM_CELLS);
    localparam int LW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;

    logic          found_reg;
    logic [AW-1:0] best_start_reg;
    logic [AW:0]   best_len_reg;
    logic [AW-1:0] run_start_reg;
    logic [AW:0]   run_len_reg;
    logic          fits;
    logic          take;
    logic          weigh;

    always_comb
    begin
        fits  = (run_len_reg != '0) && (LW'(run_len_reg) >= LW'(need));
        take  = fits && (!found_reg ||
                         (mode == MODE_BEST && run_len_reg < best_len_reg) ||
                         (mode == MODE_WORST && run_len_reg > best_len_reg));
        weigh = ctl.flush || (ctl.cell_vld && !ctl.cell_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            run_len_reg <= '0;
        end
        else if (ctl.clear)
        begin
            found_reg   <= 1'b0;
            run_len_reg <= '0;
        end
        else
        begin
            if (weigh && take)
            begin
                found_reg      <= 1'b1;
                best_start_reg <= run_start_reg;
                best_len_reg   <= run_len_reg;
            end
            if (ctl.cell_vld && ctl.cell_free)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_reg <= cell_idx;
                end
                run_len_reg <= run_len_reg + 1'b1;
            end
            else if (weigh)
            begin
                run_len_reg <= '0;
            end
        end
    end

    assign found      = found_reg;
    assign best_start = best_start_reg;

endmodule

@@ design/contiguous_fit_allocator.sv @@
// Contiguous fit allocator top level: request sequencer, cell map RAM and fit unit.
// After reset a clearing pass writes every cell free, with no request taken.
// One request is in work at a time: the next is taken only after the previous result has
// been registered on the output. Every request but a zero-size alloc scans the whole map,
// walking the single RAM read port one cell per cycle.
// Depends on cfa_pkg, cfa_ram and cfa_fit_unit.
module contiguous_fit_allocator #(
    parameter int MEM_CELLS = cfa_pkg::MEM_CELLS_DEF,
    parameter int ID_BITS   = cfa_pkg::ID_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: mode[2], request_size[13], alloc_id[16], zero pad.
    input  logic [cfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: status[2], base_index[12], granted_id[16], zero pad.
    output logic [cfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import cfa_pkg::*;

    localparam int AW = $clog2(MEM_CELLS);
    localparam logic [AW:0] CELLS_N = (AW + 1)'(MEM_CELLS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DECIDE,
        S_FILL,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW:0]            cnt_reg, cnt_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    mode_t                  mode_reg, mode_next;
    logic [SIZE_W-1:0]      need_reg, need_next;
    logic [AID_W-1:0]       want_reg, want_next;
    logic                   hit_reg, hit_next;
    logic [ID_BITS-1:0]     next_id_reg, next_id_next;
    logic [ID_BITS-1:0]     fresh_reg, fresh_next;
    logic [SIZE_W-1:0]      rem_reg, rem_next;
    status_t                res_status_reg, res_status_next;
    logic [BASE_W-1:0]      res_base_reg, res_base_next;
    logic [GID_W-1:0]       res_gid_reg, res_gid_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   accept;
    logic                   cnt_lt_n;
    logic                   match;
    logic [ID_BITS-1:0]     fresh_calc;
    mode_t                  in_mode;
    logic [SIZE_W-1:0]      in_size;
    logic [AID_W-1:0]       in_aid;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ID_BITS-1:0]     wr_data;
    logic                   rd_en;
    logic [ID_BITS-1:0]     rd_data;

    fit_ctl_t               fit_ctl;
    logic                   fit_found;
    logic [AW-1:0]          fit_start;

    cfa_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MEM_CELLS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    cfa_fit_unit #(
        .MEM_CELLS (MEM_CELLS)
    ) u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (fit_ctl),
        .mode       (mode_reg),
        .need       (need_reg),
        .cell_idx   (rd_idx_reg),
        .found      (fit_found),
        .best_start (fit_start)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    always_comb
    begin
        in_mode    = mode_t'(s_axis_tdata[MODE_W-1:0]);
        in_size    = s_axis_tdata[MODE_W +: SIZE_W];
        in_aid     = s_axis_tdata[MODE_W + SIZE_W +: AID_W];
        accept     = s_axis_tvalid && s_axis_tready;
        cnt_lt_n   = cnt_reg < CELLS_N;
        match      = (want_reg != '0) && (32'(rd_data) == 32'(want_reg));
        fresh_calc = next_id_reg + 1'b1;
        if (fresh_calc == '0)
        begin
            fresh_calc = ID_BITS'(1);
        end

        rd_en   = (state_reg == S_SCAN) && cnt_lt_n;
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_SCAN:
            begin
                wr_en   = (mode_reg == MODE_FREE) && rd_vld_reg && match;
                wr_addr = rd_idx_reg;
            end
            S_FILL:
            begin
                wr_en   = (rem_reg != '0) && cnt_lt_n;
                wr_data = fresh_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase

        fit_ctl.clear     = accept;
        fit_ctl.cell_vld  = (state_reg == S_SCAN) && rd_vld_reg && (mode_reg != MODE_FREE);
        fit_ctl.cell_free = (rd_data == '0);
        fit_ctl.flush     = (state_reg == S_FLUSH);
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = cnt_reg[AW-1:0];
        mode_next       = mode_reg;
        need_next       = need_reg;
        want_next       = want_reg;
        hit_next        = hit_reg;
        next_id_next    = next_id_reg;
        fresh_next      = fresh_reg;
        rem_next        = rem_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        res_gid_next    = res_gid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CELLS_N - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = in_mode;
                    need_next = in_size;
                    want_next = in_aid;
                    hit_next  = 1'b0;
                    cnt_next  = '0;
                    if (in_mode != MODE_FREE && in_size == '0)
                    begin
                        res_status_next = ST_ZERO;
                        res_base_next   = '0;
                        res_gid_next    = '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_vld_next = cnt_lt_n;
                if (cnt_lt_n)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (mode_reg == MODE_FREE && rd_vld_reg && match)
                begin
                    hit_next = 1'b1;
                end
                if (!cnt_lt_n && !rd_vld_reg)
                begin
                    if (mode_reg == MODE_FREE)
                    begin
                        res_status_next = hit_reg ? ST_OK : ST_NOID;
                        res_base_next   = '0;
                        res_gid_next    = hit_reg ? GID_W'(want_reg) : '0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!fit_found)
                begin
                    res_status_next = ST_NOSPACE;
                    res_base_next   = '0;
                    res_gid_next    = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    next_id_next    = fresh_calc;
                    fresh_next      = fresh_calc;
                    cnt_next        = {1'b0, fit_start};
                    rem_next        = need_reg;
                    res_status_next = ST_OK;
                    res_base_next   = BASE_W'(fit_start);
                    res_gid_next    = GID_W'(fresh_calc);
                    state_next      = S_FILL;
                end
            end
            S_FILL:
            begin
                if (rem_reg != '0 && cnt_lt_n)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, res_gid_reg, res_base_reg,
                                     res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            next_id_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            hit_reg      <= hit_next;
            next_id_reg  <= next_id_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        mode_reg       <= mode_next;
        need_reg       <= need_next;
        want_reg       <= want_next;
        fresh_reg      <= fresh_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        res_gid_reg    <= res_gid_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // A new request closes the input until its result has been produced.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in work");

    // Cells are only ever stamped with a nonzero id.
    a_fill_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> fresh_reg != '0)
        else $error("fill uses the free marker as an id");

    // Every map write lands inside the store.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> {1'b0, wr_addr} < CELLS_N)
        else $error("map write beyond the last cell");

    // A result appears only as the sequencer leaves its response step.
    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response step");

endmodule

@@ bench/tb_contiguous_fit_allocator.sv @@
// Self-checking testbench for contiguous_fit_allocator: directed and random alloc/free requests,
// each result predicted from a cell map kept here and checked field by field.
// Depends on cfa_pkg and the contiguous_fit_allocator RTL.
module tb_contiguous_fit_allocator;
    import cfa_pkg::*;

    localparam int CELLS       = MEM_CELLS_DEF;
    localparam int RANDOM_REQS = 100;
    localparam int HOLD_CYCLES = 30000;
    localparam int TAIL_CYCLES = 2 * CELLS + 64;

    typedef struct {
        mode_t              mode;
        logic [SIZE_W-1:0]  size;
        logic [AID_W-1:0]   aid;
    } request_t;

    typedef struct {
        status_t            status;
        logic [BASE_W-1:0]  base;
        logic [GID_W-1:0]   gid;
    } grant_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    request_t               request_q[$];
    grant_t                 grant_q[$];
    logic [GID_W-1:0]       cell_owner[CELLS];
    logic [GID_W-1:0]       last_id;
    int unsigned            n_queued = 0;
    int unsigned            n_accepted = 0;
    int unsigned            errors = 0;
    int unsigned            hold_left = 0;
    logic                   in_taken = 1'b0;
    logic                   out_taken = 1'b0;

    contiguous_fit_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic grant_t serve_request(request_t r);
        grant_t      g;
        logic        found;
        logic        take;
        logic        hit;
        int unsigned run_start;
        int unsigned run_len;
        int unsigned pick_start;
        int unsigned pick_len;
        int unsigned i;
        logic [GID_W-1:0] fresh;

        g.status = ST_OK;
        g.base = '0;
        g.gid = '0;
        if (r.mode == MODE_FREE)
        begin
            hit = 1'b0;
            if (r.aid != 0)
            begin
                for (i = 0; i < CELLS; i++)
                begin
                    if (cell_owner[i] == r.aid)
                    begin
                        cell_owner[i] = '0;
                        hit = 1'b1;
                    end
                end
            end
            if (hit)
                g.gid = r.aid;
            else
                g.status = ST_NOID;
        end
        else if (r.size == 0)
        begin
            g.status = ST_ZERO;
        end
        else
        begin
            found = 1'b0;
            run_start = 0;
            run_len = 0;
            pick_start = 0;
            pick_len = 0;
            for (i = 0; i <= CELLS; i++)
            begin
                if (i < CELLS && cell_owner[i] == 0)
                begin
                    if (run_len == 0)
                        run_start = i;
                    run_len++;
                end
                else
                begin
                    if (run_len != 0 && run_len >= r.size)
                    begin
                        if (!found)
                            take = 1'b1;
                        else if (r.mode == MODE_BEST)
                            take = run_len < pick_len;
                        else if (r.mode == MODE_WORST)
                            take = run_len > pick_len;
                        else
                            take = 1'b0;
                        if (take)
                        begin
                            found = 1'b1;
                            pick_start = run_start;
                            pick_len = run_len;
                        end
                    end
                    run_len = 0;
                end
            end
            if (!found)
            begin
                g.status = ST_NOSPACE;
            end
            else
            begin
                fresh = last_id + 1'b1;
                if (fresh == 0)
                    fresh = GID_W'(1);
                last_id = fresh;
                for (i = pick_start; i < pick_start + r.size && i < CELLS; i++)
                    cell_owner[i] = fresh;
                g.base = pick_start[BASE_W-1:0];
                g.gid = fresh;
            end
        end
        return g;
    endfunction

    always @(posedge clk)
    begin : check_and_predict
        grant_t   got;
        grant_t   want;
        request_t req;

        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        out_taken = rst_n && m_axis_tvalid && m_axis_tready;
        if (out_taken)
        begin
            got.status = status_t'(m_axis_tdata[STATUS_W-1:0]);
            got.base = m_axis_tdata[STATUS_W +: BASE_W];
            got.gid = m_axis_tdata[STATUS_W + BASE_W +: GID_W];
            if (grant_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = grant_q.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %s, actual %s",
                             $time, want.status.name(), got.status.name());
                    errors++;
                end
                if (got.base !== want.base)
                begin
                    $display("%0t: base_index mismatch, expected %0d, actual %0d",
                             $time, want.base, got.base);
                    errors++;
                end
                if (got.gid !== want.gid)
                begin
                    $display("%0t: granted_id mismatch, expected %0d, actual %0d",
                             $time, want.gid, got.gid);
                    errors++;
                end
            end
        end
        if (in_taken)
        begin
            req.mode = mode_t'(s_axis_tdata[MODE_W-1:0]);
            req.size = s_axis_tdata[MODE_W +: SIZE_W];
            req.aid = s_axis_tdata[MODE_W + SIZE_W +: AID_W];
            grant_q.push_back(serve_request(req));
            n_accepted++;
        end
    end

    always @(negedge clk)
    begin : request_driver
        int unsigned send_wait;
        int unsigned send_calm;
        request_t    r;

        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_wait = 0;
            send_calm = 0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            if (send_wait != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_wait--;
            end
            else if (request_q.size() != 0)
            begin
                r = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{IN_PAD_W{1'b0}}, r.aid, r.size, r.mode};
                send_wait = pick_gap(send_calm);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left = hold_left - 1;
    end

    always @(negedge clk)
    begin : result_receiver
        int unsigned recv_wait;
        int unsigned recv_calm;

        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
            recv_calm = 0;
        end
        else
        begin
            if (out_taken)
                recv_wait = pick_gap(recv_calm);
            else if (recv_wait != 0)
                recv_wait--;
            m_axis_tready <= (recv_wait == 0) && (hold_left == 0);
        end
    end

    task automatic post_request(mode_t mode, int unsigned size, logic [AID_W-1:0] aid);
        request_t r;

        r.mode = mode;
        r.size = size[SIZE_W-1:0];
        r.aid = aid;
        request_q.push_back(r);
        n_queued++;
        wait (n_accepted == n_queued);
    endtask

    task automatic post_random_request();
        int unsigned      pick;
        int unsigned      size;
        int unsigned      probe;
        logic [AID_W-1:0] aid;
        mode_t            mode;

        pick = $urandom_range(0, 99);
        aid = AID_W'($urandom);
        mode = mode_t'($urandom_range(0, 2));
        if (pick < 55)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 17)
                size = $urandom_range(1, 128);
            else if (pick < 19)
                size = $urandom_range(129, 1024);
            else
                size = $urandom_range(1, CELLS);
            post_request(mode, size, aid);
        end
        else if (pick < 90)
        begin
            for (int t = 0; t < 32; t++)
            begin
                probe = $urandom_range(0, CELLS - 1);
                if (cell_owner[probe] != 0)
                begin
                    aid = cell_owner[probe];
                    break;
                end
            end
            post_request(MODE_FREE, $urandom_range(0, 8191), aid);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: post_request(mode, 0, aid);
                1: post_request(mode, $urandom_range(CELLS + 1, 8191), aid);
                2: post_request(MODE_FREE, $urandom_range(0, 8191), aid);
                default: post_request(MODE_FREE, 0, '0);
            endcase
        end
    endtask

    initial
    begin : stimulus
        for (int i = 0; i < CELLS; i++)
            cell_owner[i] = '0;
        last_id = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        post_request(MODE_FREE, 0, '0);
        post_request(MODE_BEST, 0, 16'hABCD);
        post_request(MODE_FIRST, 8191, '0);
        post_request(MODE_WORST, CELLS + 1, '0);
        post_request(MODE_FREE, 8191, 16'hFFFF);
        post_request(MODE_FIRST, CELLS, 16'h5A5A);
        post_request(MODE_BEST, 1, '0);
        post_request(MODE_FREE, 0, 16'd1);
        post_request(MODE_FIRST, 100, '0);
        post_request(MODE_FIRST, 50, '0);
        post_request(MODE_FIRST, 300, '0);
        post_request(MODE_FIRST, 20, '0);
        post_request(MODE_FIRST, 200, '0);
        post_request(MODE_FREE, 0, 16'd3);
        post_request(MODE_FREE, 0, 16'd5);
        post_request(MODE_BEST, 20, '0);
        post_request(MODE_WORST, 10, '0);
        post_request(MODE_FIRST, 10, '0);
        post_request(MODE_BEST, 40, '0);
        post_request(MODE_FREE, 0, 16'd3);

        wait (grant_q.size() == 0);
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < RANDOM_REQS; n++)
            post_random_request();

        wait (grant_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/cfa_pkg.sv
design/cfa_ram.sv
design/cfa_fit_unit.sv
design/contiguous_fit_allocator.sv
bench/tb_contiguous_fit_allocator.sv
